FILE: rtl/core/iut_pkg.sv
// Shared types and constants of the interval union table.
// Depends on nothing; every file of the block imports it.
package iut_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int POINT_W          = 32;
   localparam int COUNT_OUT_W      = 7;

   // Item kinds on the request channel.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_COUNT  = 1'b1;

   // One stored interval, both bounds inclusive.
   typedef struct packed {
      logic [POINT_W-1:0] first;
      logic [POINT_W-1:0] last;
   } entry_type;

   // End of one insert pass, reported by the scan unit.
   typedef struct packed {
      logic valid;
      logic dropped;
   } scan_done_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } scan_state_type;

endpackage

FILE: rtl/core/iut_mem.sv
// Interval storage: one synchronous memory of start/end pairs.
// One write port and one read port, read data registered. Uses iut_pkg.
module iut_mem #(
   parameter int DEPTH = iut_pkg::DEFAULT_CAPACITY,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic [IDX_W-1:0]    rd_addr,
   output iut_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  iut_pkg::entry_type  wr_data
);
   import iut_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/iut_scan.sv
// Insert sequencer: streams the sorted table through the memory once,
// merging the new range and compacting or shifting entries in place.
// Uses iut_pkg; drives the ports of iut_mem.
module iut_scan #(
   parameter int CAPACITY = iut_pkg::DEFAULT_CAPACITY,
   parameter int CNT_W    = $clog2(CAPACITY + 1),
   parameter int IDX_W    = $clog2(CAPACITY)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  logic [iut_pkg::POINT_W-1:0]  range_first,
   input  logic [iut_pkg::POINT_W-1:0]  range_last,
   input  logic [CNT_W-1:0]             count,
   output logic                         busy,
   output iut_pkg::scan_done_type       done,
   output logic [CNT_W-1:0]             new_count,
   output logic [IDX_W-1:0]             mem_rd_addr,
   input  iut_pkg::entry_type           mem_rd_data,
   output logic                         mem_wr_en,
   output logic [IDX_W-1:0]             mem_wr_addr,
   output iut_pkg::entry_type           mem_wr_data
);
   import iut_pkg::*;

   scan_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   wptr_ff, wptr_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [POINT_W-1:0] first_ff, first_in;
   logic [POINT_W-1:0] last_ff, last_in;
   entry_type          acc_ff, acc_in;
   entry_type          pend_ff, pend_in;
   logic               merged_ff, merged_in;
   logic               placed_ff, placed_in;

   logic [CNT_W-1:0]   idx_next;
   logic               is_left, is_merge, place_now, drop_now, drop_flush;
   logic               last_entry, is_full;

   // Adjacency tests are done one bit wider so that the top point does not wrap.
   assign is_left    = ({1'b0, mem_rd_data.last} + 33'd1) < {1'b0, first_ff};
   assign is_merge   = {1'b0, mem_rd_data.first} <= ({1'b0, last_ff} + 33'd1);
   assign place_now  = !placed_ff && !is_left && !is_merge;
   assign is_full    = n_ff == CNT_W'(CAPACITY);
   assign drop_now   = place_now && !merged_ff && is_full;
   assign drop_flush = !placed_ff && !merged_ff && is_full;
   assign idx_next   = idx_ff + CNT_W'(1);
   assign last_entry = idx_ff == (n_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff    <= idx_in;
      wptr_ff   <= wptr_in;
      n_ff      <= n_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      acc_ff    <= acc_in;
      pend_ff   <= pend_in;
      merged_ff <= merged_in;
      placed_ff <= placed_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = (count == '0) ? ST_FLUSH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (drop_now) begin
               state_in = ST_IDLE;
            end else if (last_entry) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs: memory ports and completion.
   always_comb begin
      busy         = state_ff != ST_IDLE;
      mem_rd_addr  = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wptr_ff[IDX_W-1:0];
      mem_wr_data  = acc_ff;
      done         = '0;
      new_count    = wptr_ff;
      case (state_ff)
         ST_IDLE: begin
            mem_rd_addr = '0;
         end
         ST_SCAN: begin
            mem_rd_addr = idx_next[IDX_W-1:0];
            if (placed_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = pend_ff;
            end else if (place_now && !drop_now) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = acc_ff;
            end
            done.valid   = drop_now;
            done.dropped = drop_now;
            new_count    = n_ff;
         end
         ST_FLUSH: begin
            mem_wr_en    = !drop_flush;
            mem_wr_data  = placed_ff ? pend_ff : acc_ff;
            done.valid   = 1'b1;
            done.dropped = drop_flush;
            new_count    = drop_flush ? n_ff : wptr_ff + CNT_W'(1);
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      idx_in    = idx_ff;
      wptr_in   = wptr_ff;
      n_in      = n_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      merged_in = merged_ff;
      placed_in = placed_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               idx_in    = '0;
               wptr_in   = '0;
               n_in      = count;
               first_in  = range_first;
               last_in   = range_last;
               acc_in    = '{first: range_first, last: range_last};
               merged_in = 1'b0;
               placed_in = 1'b0;
            end
         end
         ST_SCAN: begin
            idx_in = idx_next;
            if (placed_ff) begin
               wptr_in = wptr_ff + CNT_W'(1);
               pend_in = mem_rd_data;
            end else if (is_left) begin
               // Entry lies wholly below the new range and keeps its place.
               wptr_in = wptr_ff + CNT_W'(1);
            end else if (is_merge) begin
               if (mem_rd_data.first < acc_ff.first) begin
                  acc_in.first = mem_rd_data.first;
               end
               if (mem_rd_data.last > acc_ff.last) begin
                  acc_in.last = mem_rd_data.last;
               end
               merged_in = 1'b1;
            end else begin
               wptr_in   = wptr_ff + CNT_W'(1);
               pend_in   = mem_rd_data;
               placed_in = 1'b1;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // The write pointer never passes the entry being read, so no overlap.
   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && mem_wr_en) |-> (wptr_ff <= idx_ff))
      else $error("scan write overtook the read stream");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      (done.valid && done.dropped) |-> (is_full && !merged_ff && !placed_ff))
      else $error("insert dropped while a free entry or merge existed");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      done.valid |-> (new_count <= CNT_W'(CAPACITY)))
      else $error("new interval count exceeds capacity");

endmodule

FILE: rtl/core/interval_union_table.sv
// Top level of the interval union table: request decode, stored count,
// response register. Instantiates iut_mem and iut_scan; uses iut_pkg.
//
//  Channel  Ports                                     Transfer when
//  -------  ----------------------------------------  -------------------
//  request  start, busy, req_kind, req_range_start,   start && !busy
//           req_range_end
//  response rsp_valid, rsp_interval_count,            rsp_valid (one cycle)
//           rsp_table_full
//
// A count item, or an insert whose end lies below its start, answers in the
// cycle after its transfer and leaves the table unchanged.
// An insert streams the stored intervals through the single memory read port,
// one entry a cycle, and answers once the whole table has been read; an insert
// dropped on a full table may end sooner, before the last entry is read.
// Reset clears the control state and the stored count; the memory needs no
// clearing because entries at or beyond the count are never used.
// The receiver cannot stall: the response strobe is high for exactly one cycle,
// and a new request may transfer in that same cycle.
module interval_union_table #(
   parameter int CAPACITY = iut_pkg::DEFAULT_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_kind,
   input  logic [iut_pkg::POINT_W-1:0]      req_range_start,
   input  logic [iut_pkg::POINT_W-1:0]      req_range_end,
   output logic                             rsp_valid,
   output logic [iut_pkg::COUNT_OUT_W-1:0]  rsp_interval_count,
   output logic                             rsp_table_full
);
   import iut_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   logic [CNT_W-1:0]   stored_count_ff, stored_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic               rsp_full_ff, rsp_full_in;

   logic               accept;
   logic               is_insert;
   logic               scan_go;
   logic               scan_busy;
   scan_done_type      scan_done;
   logic [CNT_W-1:0]   scan_count;
   logic [IDX_W-1:0]   mem_rd_addr;
   entry_type          mem_rd_data;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   entry_type          mem_wr_data;

   // Only a well-formed insert starts a pass over the table; every other
   // item is answered straight from the stored count.
   assign accept    = start && !busy;
   assign is_insert = (req_kind == KIND_INSERT) && (req_range_end >= req_range_start);
   assign scan_go   = accept && is_insert;
   assign busy      = scan_busy;

   iut_mem #(
      .DEPTH (CAPACITY),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   iut_scan #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W),
      .IDX_W    (IDX_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .go          (scan_go),
      .range_first (req_range_start),
      .range_last  (req_range_end),
      .count       (stored_count_ff),
      .busy        (scan_busy),
      .done        (scan_done),
      .new_count   (scan_count),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // The response register is loaded either by a finished pass or by an
   // item that needs no pass. The two never coincide, since a request can
   // only transfer while no pass is running.
   always_comb begin
      stored_count_in = stored_count_ff;
      rsp_valid_in    = 1'b0;
      rsp_count_in    = rsp_count_ff;
      rsp_full_in     = rsp_full_ff;
      if (scan_done.valid) begin
         stored_count_in = scan_count;
         rsp_valid_in    = 1'b1;
         rsp_count_in    = scan_count;
         rsp_full_in     = scan_done.dropped;
      end else if (accept && !is_insert) begin
         rsp_valid_in    = 1'b1;
         rsp_count_in    = stored_count_ff;
         rsp_full_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         stored_count_ff <= stored_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_interval_count = COUNT_OUT_W'(rsp_count_ff);
   assign rsp_table_full     = rsp_valid_ff && rsp_full_ff;

   // Every transfer is either answered next cycle or starts a pass.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid || busy))
      else $error("request transfer neither answered nor started");

   // The stored count only moves at the end of a pass.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !scan_done.valid |=> $stable(stored_count_ff))
      else $error("stored count changed outside a pass completion");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      stored_count_ff <= CNT_W'(CAPACITY))
      else $error("stored count exceeds capacity");

   // A drop is only reported when the table was already full.
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_table_full |-> (rsp_count_ff == CNT_W'(CAPACITY)))
      else $error("full flag raised below capacity");

endmodule
